FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the condition holds, the expression holds in the cycle after.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

FILE: rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Types, codes and constants of the text console cursor and scroll unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths of the request and result items.
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CELL_W   = 16;
    localparam int USER_W   = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam logic [USER_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [USER_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [USER_W-1:0] REQ_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    // Packed from the top bit down; cell_value sits in the lowest bits.
    typedef struct packed {
        logic              scrolled;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_value;
    } result_t;

endpackage

FILE: rtl/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit
// Path: each result passes the pending and output registers to m_tvalid, a read
// first the memory read register. Throughput: put characters 1 per cycle while
// no sweep runs and the result path is free; a read holds s_tready low in ST_READ.
// A scroll blanks the recycled row, a clear sweeps all ROWS*COLUMNS cells;
// s_tready stays low during either sweep. Reset: cursor homed, attribute 0x07,
// then a blanking pass over all ROWS*COLUMNS cells before the first request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // char_code[7:0], read_row[12:8], read_col[19:13]
    input  logic [tcc_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [tcc_pkg::USER_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28]
    output logic [tcc_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcc_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Physical row of a row sum, such as a logical row plus the row that shows on top.
    function automatic logic [RW-1:0] wrap_row(input logic [RW:0] r);
        logic [RW:0] d;
        begin
            d = r - (RW+1)'(ROWS);
            wrap_row = (32'(r) >= ROWS) ? d[RW-1:0] : r[RW-1:0];
        end
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
        begin
            addr_of = AW'(32'(prow) * COLUMNS + 32'(col));
        end
    endfunction

    state_t              state_reg, state_next;
    logic [RW-1:0]       cursor_row_reg, cursor_row_next;
    logic [CW-1:0]       cursor_col_reg, cursor_col_next;
    logic [RW-1:0]       top_reg, top_next;
    logic [7:0]          attribute_reg, attribute_next;
    logic [7:0]          fill_attr_reg, fill_attr_next;
    logic [AW-1:0]       sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]       sweep_last_reg, sweep_last_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0]   rd_data_reg;

    logic [CELL_W-1:0]   cell_mem [CELLS];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic                accept;
    logic                out_free;
    logic                pend_move;
    logic                pend_load;
    result_t             pend_data;
    logic                scroll_now;
    logic                adv_row;
    logic [RW:0]         row_inc;
    logic [CW:0]         col_inc;
    logic [RW-1:0]       cur_prow;
    logic [RW-1:0]       rd_row_idx;
    logic [CW-1:0]       rd_col_idx;
    logic [CHAR_W-1:0]   in_char;
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;

    assign in_char = s_tdata[7:0];
    assign in_row  = s_tdata[12:8];
    assign in_col  = s_tdata[19:13];

    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    assign s_tready  = (state_reg == ST_IDLE) && (!pend_valid_reg || out_free);
    assign accept    = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

    assign row_inc    = {1'b0, cursor_row_reg} + (RW+1)'(1);
    assign col_inc    = {1'b0, cursor_col_reg} + (CW+1)'(1);
    assign cur_prow   = wrap_row({1'b0, cursor_row_reg} + {1'b0, top_reg});
    assign rd_row_idx = RW'(in_row);
    assign rd_col_idx = CW'(in_col);

    always_comb
    begin
        state_next      = state_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        top_next        = top_reg;
        attribute_next  = cfg_wr_en ? cfg_wr_data : attribute_reg;
        fill_attr_next  = fill_attr_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        rd_ok_next      = rd_ok_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = {fill_attr_reg, CH_SPACE};
        mem_re          = 1'b0;
        mem_raddr       = '0;
        pend_load       = 1'b0;
        pend_data       = '0;
        scroll_now      = 1'b0;
        adv_row         = 1'b0;

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            ST_READ:
            begin
                pend_load            = 1'b1;
                pend_data.cell_value = rd_ok_reg ? rd_data_reg : '0;
                pend_data.cursor_row = ROW_W'(cursor_row_reg);
                pend_data.cursor_col = COL_W'(cursor_col_reg);
                state_next           = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        REQ_PUT:
                        begin
                            if (in_char == CH_LF)
                            begin
                                cursor_col_next = '0;
                                adv_row         = 1'b1;
                            end
                            else if (in_char == CH_CR)
                            begin
                                cursor_col_next = '0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_of(cur_prow, cursor_col_reg);
                                mem_wdata = {attribute_reg, in_char};
                                if (32'(col_inc) >= COLUMNS)
                                begin
                                    cursor_col_next = '0;
                                    adv_row         = 1'b1;
                                end
                                else
                                begin
                                    cursor_col_next = col_inc[CW-1:0];
                                end
                            end
                            if (adv_row)
                            begin
                                if (32'(row_inc) >= ROWS)
                                begin
                                    // The top row is recycled as the new bottom row.
                                    scroll_now      = 1'b1;
                                    cursor_row_next = RW'(ROWS - 1);
                                    cursor_col_next = '0;
                                    top_next        = wrap_row({1'b0, top_reg} + (RW+1)'(1));
                                    sweep_addr_next = addr_of(top_reg, '0);
                                    sweep_last_next = addr_of(top_reg, CW'(COLUMNS - 1));
                                    fill_attr_next  = attribute_reg;
                                    state_next      = ST_SWEEP;
                                end
                                else
                                begin
                                    cursor_row_next = row_inc[RW-1:0];
                                end
                            end
                            pend_load            = 1'b1;
                            pend_data.scrolled   = scroll_now;
                            pend_data.cursor_row = ROW_W'(cursor_row_next);
                            pend_data.cursor_col = COL_W'(cursor_col_next);
                        end
                        REQ_CLEAR:
                        begin
                            cursor_row_next = '0;
                            cursor_col_next = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = AW'(CELLS - 1);
                            fill_attr_next  = attribute_reg;
                            state_next      = ST_SWEEP;
                            pend_load       = 1'b1;
                        end
                        REQ_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = addr_of(wrap_row({1'b0, rd_row_idx} + {1'b0, top_reg}),
                                                 rd_col_idx);
                            rd_ok_next = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            pend_load            = 1'b1;
                            pend_data.cursor_row = ROW_W'(cursor_row_reg);
                            pend_data.cursor_col = COL_W'(cursor_col_reg);
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Two-entry result path: a pending register ahead of the output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
        end
        else if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        pend_valid_next = pend_valid_reg && !pend_move;
        pend_next       = pend_reg;
        if (pend_load)
        begin
            pend_valid_next = 1'b1;
            pend_next       = pend_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            top_reg        <= '0;
            attribute_reg  <= ATTR_RESET;
            fill_attr_reg  <= ATTR_RESET;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(CELLS - 1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            top_reg        <= top_next;
            attribute_reg  <= attribute_next;
            fill_attr_reg  <= fill_attr_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        out_reg   <= out_next;
        rd_ok_reg <= rd_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    `ASSERT_ALWAYS(a_cursor_row_range, 32'(cursor_row_reg) < ROWS, "cursor row left the grid")
    `ASSERT_ALWAYS(a_top_row_range, 32'(top_reg) < ROWS, "top row pointer left the grid")
    `ASSERT_ALWAYS(a_pend_no_overwrite, !pend_load || !pend_valid_reg || pend_move, "pending result overwritten")
    `ASSERT_NEXT(a_scroll_blanks_row, accept && scroll_now, (state_reg == ST_SWEEP) && (cursor_col_reg == '0), "scroll did not start row blanking")

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Text console cursor and scroll unit testbench
// Drives put, clear, read and unused requests over the slave stream and checks
// every result on the master stream against a cycle-free model of the grid,
// the cursor and the attribute register, or a directed row's fixed result.
// A directed table comes first, then random phases under several attribute
// settings, with random gaps on both sides of the block in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import tcc_pkg::*;

    localparam int COLS        = DEF_COLUMNS;
    localparam int LINES       = DEF_ROWS;
    localparam int CELLS       = COLS * LINES;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 100;

    localparam logic [USER_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [USER_W-1:0] req;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        bit                fixed;
        result_t           res;
    } table_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [7:0]            cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [USER_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // Model of the console.
    logic [CELL_W-1:0]     grid_model [CELLS];
    int                    cur_row;
    int                    cur_col;
    logic [7:0]            attr_model;

    result_t               pending_results [$];
    table_row_t            dir_table [$];

    // Typed expectation of the request on the bus, if any.
    bit                    cur_fixed_on;
    result_t               cur_fixed;

    bit                    src_idle_on;
    bit                    snk_idle_on;
    int                    err_cnt;
    int                    stall_cnt;
    result_t               got_res;
    result_t               want_res;
    result_t               pred_res;

    text_console_cursor_scroll_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void blank_grid(input logic [7:0] attr);
        for (int i = 0; i < CELLS; i++)
        begin
            grid_model[i] = {attr, CH_SPACE};
        end
    endfunction

    // Moves every row up by one and blanks the bottom row once the cursor has left the bottom row.
    function automatic bit bottom_scroll();
        if (cur_row < LINES)
        begin
            return 1'b0;
        end
        for (int i = 0; i + COLS < CELLS; i++)
        begin
            grid_model[i] = grid_model[i + COLS];
        end
        for (int i = (LINES - 1) * COLS; i < CELLS; i++)
        begin
            grid_model[i] = {attr_model, CH_SPACE};
        end
        cur_row = LINES - 1;
        cur_col = 0;
        return 1'b1;
    endfunction

    task automatic console_apply(input logic [USER_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                 input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                 output result_t res);
        bit did_scroll;
        did_scroll = 1'b0;
        res = '0;
        case (req)
            REQ_PUT:
            begin
                if (ch == CH_LF)
                begin
                    cur_col = 0;
                    cur_row++;
                    did_scroll = bottom_scroll();
                end
                else if (ch == CH_CR)
                begin
                    cur_col = 0;
                end
                else
                begin
                    grid_model[cur_row * COLS + cur_col] = {attr_model, ch};
                    cur_col++;
                    if (cur_col >= COLS)
                    begin
                        cur_col = 0;
                        cur_row++;
                        did_scroll = bottom_scroll();
                    end
                end
            end
            REQ_CLEAR:
            begin
                blank_grid(attr_model);
                cur_row = 0;
                cur_col = 0;
            end
            REQ_READ:
            begin
                if (rr < LINES && rc < COLS)
                begin
                    res.cell_value = grid_model[rr * COLS + rc];
                end
            end
            default:
            begin
            end
        endcase
        res.cursor_row = cur_row[ROW_W-1:0];
        res.cursor_col = cur_col[COL_W-1:0];
        res.scrolled   = did_scroll;
    endtask

    function automatic table_row_t mk_row(input logic [USER_W-1:0] req,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [ROW_W-1:0] rr,
                                          input logic [COL_W-1:0] rc, input bit fixed,
                                          input logic [CELL_W-1:0] cell_val,
                                          input logic [ROW_W-1:0] crow,
                                          input logic [COL_W-1:0] ccol);
        table_row_t row;
        row.req              = req;
        row.ch               = ch;
        row.rr               = rr;
        row.rc               = rc;
        row.fixed            = fixed;
        row.res.cell_value   = cell_val;
        row.res.cursor_row   = crow;
        row.res.cursor_col   = ccol;
        row.res.scrolled     = 1'b0;
        return row;
    endfunction

    // Attribute tracking, result checking and prediction, all sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                attr_model = cfg_wr_data;
            end
            if (m_tvalid && m_tready)
            begin
                got_res = result_t'(m_tdata[28:0]);
                if (pending_results.size() == 0)
                begin
                    if (err_cnt < 10)
                    begin
                        $display("%0t: result with nothing expected: %h", $realtime, m_tdata);
                    end
                    err_cnt++;
                end
                else
                begin
                    want_res = pending_results.pop_front();
                    if (got_res.cell_value !== want_res.cell_value
                        || got_res.cursor_row !== want_res.cursor_row
                        || got_res.cursor_col !== want_res.cursor_col
                        || got_res.scrolled !== want_res.scrolled)
                    begin
                        if (err_cnt < 10)
                        begin
                            $display("%0t: mismatch cell %h/%h row %0d/%0d col %0d/%0d scr %0b/%0b",
                                     $realtime, want_res.cell_value, got_res.cell_value,
                                     want_res.cursor_row, got_res.cursor_row,
                                     want_res.cursor_col, got_res.cursor_col,
                                     want_res.scrolled, got_res.scrolled);
                        end
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                console_apply(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[19:13], pred_res);
                pending_results.push_back(cur_fixed_on ? cur_fixed : pred_res);
            end
        end
    end

    // Watchdog on cycles in which neither stream completes a handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cnt = 0;
        end
        else
        begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready = 1'b0;
        end
        else if (snk_idle_on)
        begin
            m_tready = ($urandom_range(0, 99) >= 29);
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    task automatic send_request(input logic [USER_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                input bit fixed, input result_t fixed_res);
        // Each idle cycle is drawn on its own, with a chance of 29 in 100.
        while (src_idle_on && $urandom_range(0, 99) < 29)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid     = 1'b1;
        s_tuser      = req;
        s_tdata      = {4'b0, rc, rr, ch};
        cur_fixed_on = fixed;
        cur_fixed    = fixed_res;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
        s_tvalid     = 1'b0;
        cur_fixed_on = 1'b0;
    endtask

    // Waits until all results are in and any row or grid sweep has finished.
    task automatic wait_quiet();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        while (!s_tready)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    initial
    begin
        logic [USER_W-1:0] req;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        logic [7:0]        attrs [5];
        int                pick;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cur_fixed_on = 1'b0;
        cur_fixed    = '0;
        src_idle_on  = 1'b1;
        snk_idle_on  = 1'b1;
        err_cnt      = 0;
        stall_cnt    = 0;
        attr_model   = ATTR_RESET;
        cur_row      = 0;
        cur_col      = 0;
        blank_grid(ATTR_RESET);

        // Reset state, reads outside the grid, the unused request, character
        // extremes, carriage return, line feed and clear.
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd0,  7'd0,   1'b1, 16'h0720, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd24, 7'd79,  1'b1, 16'h0720, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd25, 7'd0,   1'b1, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd0,  7'd80,  1'b1, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'hFF, 5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_PUT,    8'h41, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd1));
        dir_table.push_back(mk_row(REQ_PUT,    8'h00, 5'd31, 7'd127, 1'b1, 16'h0000, 5'd0, 7'd2));
        dir_table.push_back(mk_row(REQ_PUT,    8'hFF, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd3));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd0,  7'd0,   1'b1, 16'h0741, 5'd0, 7'd3));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd0,  7'd2,   1'b1, 16'h07FF, 5'd0, 7'd3));
        dir_table.push_back(mk_row(REQ_PUT,    CH_CR, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_PUT,    CH_LF, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd1, 7'd0));
        dir_table.push_back(mk_row(REQ_PUT,    8'h5A, 5'd0,  7'd0,   1'b0, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd1,  7'd0,   1'b0, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd0,  7'd1,   1'b0, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_CLEAR,  8'h00, 5'd0,  7'd0,   1'b1, 16'h0000, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd0,  7'd0,   1'b1, 16'h0720, 5'd0, 7'd0));
        dir_table.push_back(mk_row(REQ_READ,   8'h00, 5'd1,  7'd0,   1'b1, 16'h0720, 5'd0, 7'd0));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // The blanking pass after reset holds s_tready low.
        wait_quiet();

        foreach (dir_table[i])
        begin
            send_request(dir_table[i].req, dir_table[i].ch, dir_table[i].rr, dir_table[i].rc,
                         dir_table[i].fixed, dir_table[i].res);
        end

        attrs[0] = 8'h00;
        attrs[1] = 8'hFF;
        attrs[2] = 8'($urandom_range(0, 255));
        attrs[3] = 8'($urandom_range(0, 255));
        attrs[4] = ATTR_RESET;

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_quiet();
            write_attribute(attrs[ph]);
            src_idle_on = (ph != 2);
            snk_idle_on = (ph != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 999);
                ch   = CHAR_W'($urandom_range(0, 255));
                rr   = ROW_W'($urandom_range(0, 31));
                rc   = COL_W'($urandom_range(0, 127));
                // Clears are kept rare so that the cursor reaches the bottom.
                if (pick < 3)
                begin
                    req = REQ_CLEAR;
                end
                else if (pick < 30)
                begin
                    req = REQ_UNUSED;
                end
                else if (pick < 280)
                begin
                    req = REQ_READ;
                    if ($urandom_range(0, 99) < 85)
                    begin
                        rr = ROW_W'($urandom_range(0, LINES - 1));
                        rc = COL_W'($urandom_range(0, COLS - 1));
                    end
                end
                else
                begin
                    req = REQ_PUT;
                    pick = $urandom_range(0, 99);
                    if (pick < 25)
                    begin
                        ch = CH_LF;
                    end
                    else if (pick < 30)
                    begin
                        ch = CH_CR;
                    end
                end
                send_request(req, ch, rr, rc, 1'b0, '0);
            end
        end

        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (err_cnt == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/text_console_cursor_scroll_unit.sv
test/tb.sv
